>>> design/swgc_pkg.sv
// Shared types, constants and the per-base contribution table for the
// sliding-window GC content unit. No dependencies.
package swgc_pkg;

    localparam int MAX_HALF_WINDOW = 63;
    localparam int HALF_W          = 6;
    localparam int LINE_ADDR_W     = $clog2(2 * MAX_HALF_WINDOW + 1);
    localparam int SEEN_W          = 7;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [HALF_W-1:0] HALF_WINDOW_RESET = 6'd24;
    localparam logic              REG_HALF_WINDOW   = 1'b0;

    // Shares of one base, in sixths.
    typedef struct packed {
        logic [2:0] gc;
        logic [2:0] ade;
        logic [2:0] thy;
    } t_contrib;

    // One classified base as it leaves the front queue.
    typedef struct packed {
        t_contrib   share;
        logic [1:0] phase;
        logic       eos;
    } t_entry;

    // One entry of the base history memory.
    typedef struct packed {
        t_contrib   share;
        logic [1:0] phase;
    } t_line;

    // Queue head offered to the back end.
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_queue_head;

    // Sixths of a base for each nucleotide mask: bit0 A, bit1 C, bit2 G, bit3 T.
    function automatic t_contrib base_contrib(input logic [3:0] code);
        t_contrib c;
        c = '{gc: 3'd0, ade: 3'd0, thy: 3'd0};
        case (code)
            4'h1: c = '{gc: 3'd0, ade: 3'd6, thy: 3'd0};
            4'h2: c = '{gc: 3'd6, ade: 3'd0, thy: 3'd0};
            4'h3: c = '{gc: 3'd3, ade: 3'd6, thy: 3'd0};
            4'h4: c = '{gc: 3'd6, ade: 3'd0, thy: 3'd0};
            4'h5: c = '{gc: 3'd3, ade: 3'd6, thy: 3'd0};
            4'h6: c = '{gc: 3'd6, ade: 3'd0, thy: 3'd0};
            4'h7: c = '{gc: 3'd4, ade: 3'd6, thy: 3'd0};
            4'h8: c = '{gc: 3'd0, ade: 3'd0, thy: 3'd6};
            4'h9: c = '{gc: 3'd0, ade: 3'd3, thy: 3'd3};
            4'hA: c = '{gc: 3'd3, ade: 3'd0, thy: 3'd6};
            4'hB: c = '{gc: 3'd2, ade: 3'd3, thy: 3'd3};
            4'hC: c = '{gc: 3'd3, ade: 3'd0, thy: 3'd6};
            4'hD: c = '{gc: 3'd2, ade: 3'd3, thy: 3'd3};
            4'hE: c = '{gc: 3'd4, ade: 3'd0, thy: 3'd6};
            4'hF: c = '{gc: 3'd3, ade: 3'd3, thy: 3'd3};
            default: c = '{gc: 3'd0, ade: 3'd0, thy: 3'd0};
        endcase
        return c;
    endfunction

endpackage

>>> design/swgc_if.sv
// Input and result channel interfaces of the sliding-window GC content unit.
// Depends on nothing; payload widths follow the channel field definitions.
interface swgc_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] base_code;
    logic       end_of_sequence;

    modport source (output valid, output base_code, output end_of_sequence, input ready);
    modport sink   (input valid, input base_code, input end_of_sequence, output ready);
endinterface

interface swgc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] gc_frame_zero;
    logic [7:0] gc_frame_one;
    logic [7:0] gc_frame_two;
    logic [9:0] adenine_sum;
    logic [9:0] thymine_sum;
    logic [6:0] window_width;
    logic       last_of_run;
    logic       last_of_sequence;

    modport source (output valid, output gc_frame_zero, output gc_frame_one,
                    output gc_frame_two, output adenine_sum, output thymine_sum,
                    output window_width, output last_of_run, output last_of_sequence,
                    input ready);
    modport sink   (input valid, input gc_frame_zero, input gc_frame_one,
                    input gc_frame_two, input adenine_sum, input thymine_sum,
                    input window_width, input last_of_run, input last_of_sequence,
                    output ready);
endinterface

>>> design/swgc_front.sv
// Front end: accepts bases, classifies each into its sixths shares and frame
// phase, and queues them for the back end. Depends on swgc_pkg and swgc_in_if.
module swgc_front
    import swgc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    swgc_in_if.sink       i_in,
    output t_queue_head   o_head,
    input  logic          i_pop
);

    t_entry                 r_queue [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wp;
    logic [QUEUE_PTR_W-1:0] r_rp;
    logic [QUEUE_CNT_W-1:0] r_cnt;
    logic [1:0]             r_phase;
    logic                   push;
    logic                   pop;
    t_entry                 new_entry;

    assign i_in.ready = (r_cnt != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_pop && (r_cnt != '0);

    assign new_entry.share = base_contrib(i_in.base_code);
    assign new_entry.phase = r_phase;
    assign new_entry.eos   = i_in.end_of_sequence;

    assign o_head.valid = (r_cnt != '0);
    assign o_head.entry = r_queue[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
            r_phase <= 2'd0;
        end else begin
            if (push) begin
                r_queue[r_wp] <= new_entry;
                r_wp          <= r_wp + 1'b1;
                // The frame phase restarts with every new sequence.
                if (i_in.end_of_sequence || r_phase == 2'd2) begin
                    r_phase <= 2'd0;
                end else begin
                    r_phase <= r_phase + 2'd1;
                end
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> design/swgc_back.sv
// Back end: keeps the base history memory and window sums, emits one result per
// position, runs the end-of-sequence flush. Depends on swgc_pkg, swgc_out_if.
module swgc_back
    import swgc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [HALF_W-1:0] i_half,
    input  t_queue_head       i_head,
    output logic              o_pop,
    swgc_out_if.source        o_out
);

    typedef enum logic {S_RUN, S_FLUSH} t_state;

    localparam int LINE_DEPTH = 2 ** LINE_ADDR_W;

    t_line                  r_mem [LINE_DEPTH];
    t_line                  r_rd_data;
    logic [LINE_ADDR_W-1:0] r_rd_addr;
    logic [LINE_ADDR_W-1:0] rd_addr;
    logic [LINE_ADDR_W-1:0] r_wa;

    t_state                 r_state;
    logic                   r_cur_valid;
    t_entry                 r_cur;
    logic [SEEN_W-1:0]      r_seen;
    logic [HALF_W-1:0]      r_m;
    logic [HALF_W-1:0]      r_count;

    logic [7:0]             r_gc [3];
    logic [9:0]             r_ade;
    logic [9:0]             r_thy;
    logic [6:0]             r_width;
    logic [7:0]             n_gc [3];
    logic [9:0]             n_ade;
    logic [9:0]             n_thy;
    logic [6:0]             n_width;

    logic                   r_ovalid;
    logic [7:0]             r_o_gc [3];
    logic [9:0]             r_o_ade;
    logic [9:0]             r_o_thy;
    logic [6:0]             r_o_width;
    logic                   r_o_last_run;
    logic                   r_o_last_seq;

    logic [LINE_ADDR_W-1:0] span;
    logic                   emit_run;
    logic                   rem_run;
    logic                   out_free;
    logic                   run_go;
    logic                   flush_go;
    logic                   flush_rem;
    logic                   flush_last;
    logic                   pop;
    logic                   add_en;
    logic                   rem_en;
    logic                   out_load;

    assign span       = {i_half, 1'b0};
    assign emit_run   = (r_seen >= SEEN_W'(i_half));
    assign rem_run    = (r_seen >= SEEN_W'(span));
    assign out_free   = !r_ovalid || o_out.ready;
    assign run_go     = (r_state == S_RUN) && r_cur_valid && (!emit_run || out_free);
    assign flush_go   = (r_state == S_FLUSH) && out_free;
    assign flush_rem  = emit_run &&
                        (({1'b0, r_seen} + {{(SEEN_W + 1 - HALF_W){1'b0}}, r_m})
                         >= {1'b0, SEEN_W'(span)});
    assign flush_last = (r_m == r_count);
    assign pop        = i_head.valid && (r_state == S_RUN) &&
                        (!r_cur_valid || (run_go && !r_cur.eos));
    assign o_pop      = pop;
    assign out_load   = (run_go && emit_run) || flush_go;

    // A new base reads the base leaving its window; the flush walks forward
    // from there one entry per result.
    always_comb begin
        rd_addr = r_rd_addr;
        if (pop) begin
            rd_addr = r_wa - span;
        end else if ((run_go && r_cur.eos) || flush_go) begin
            rd_addr = r_rd_addr + 1'b1;
        end
    end

    always_comb begin
        add_en = (r_state == S_RUN);
        rem_en = (r_state == S_RUN) ? rem_run : flush_rem;
        for (int f = 0; f < 3; f++) begin
            n_gc[f] = r_gc[f];
            if (add_en && r_cur.phase == 2'(f)) begin
                n_gc[f] = n_gc[f] + {5'd0, r_cur.share.gc};
            end
            if (rem_en && r_rd_data.phase == 2'(f)) begin
                n_gc[f] = n_gc[f] - {5'd0, r_rd_data.share.gc};
            end
        end
        n_ade   = r_ade + (add_en ? {7'd0, r_cur.share.ade} : 10'd0)
                        - (rem_en ? {7'd0, r_rd_data.share.ade} : 10'd0);
        n_thy   = r_thy + (add_en ? {7'd0, r_cur.share.thy} : 10'd0)
                        - (rem_en ? {7'd0, r_rd_data.share.thy} : 10'd0);
        n_width = r_width + (add_en ? 7'd1 : 7'd0) - (rem_en ? 7'd1 : 7'd0);
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_mem[r_wa] <= '{share: i_head.entry.share, phase: i_head.entry.phase};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_cur_valid <= 1'b0;
            r_wa        <= '0;
            r_rd_addr   <= '0;
            r_seen      <= '0;
            r_ovalid    <= 1'b0;
            r_ade       <= '0;
            r_thy       <= '0;
            r_width     <= '0;
            for (int f = 0; f < 3; f++) begin
                r_gc[f] <= '0;
            end
        end else begin
            r_rd_addr <= rd_addr;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (pop) begin
                r_cur <= i_head.entry;
                r_wa  <= r_wa + 1'b1;
            end
            case (r_state)
                S_RUN: begin
                    if (pop) begin
                        r_cur_valid <= 1'b1;
                    end else if (run_go && !r_cur.eos) begin
                        r_cur_valid <= 1'b0;
                    end
                    if (run_go) begin
                        r_gc    <= n_gc;
                        r_ade   <= n_ade;
                        r_thy   <= n_thy;
                        r_width <= n_width;
                        if (emit_run) begin
                            r_o_gc       <= n_gc;
                            r_o_ade      <= n_ade;
                            r_o_thy      <= n_thy;
                            r_o_width    <= n_width;
                            r_o_last_run <= !r_cur.eos;
                            r_o_last_seq <= 1'b0;
                        end
                        if (r_cur.eos) begin
                            r_state <= S_FLUSH;
                            r_m     <= HALF_W'(1);
                            r_count <= emit_run ? i_half : r_seen[HALF_W-1:0] + 1'b1;
                        end else if (r_seen != '1) begin
                            r_seen <= r_seen + 1'b1;
                        end
                    end
                end
                S_FLUSH: begin
                    if (flush_go) begin
                        r_o_gc       <= n_gc;
                        r_o_ade      <= n_ade;
                        r_o_thy      <= n_thy;
                        r_o_width    <= n_width;
                        r_o_last_run <= flush_last;
                        r_o_last_seq <= flush_last;
                        r_m          <= r_m + 1'b1;
                        if (flush_last) begin
                            // The sequence is done: start the next one from empty.
                            r_state     <= S_RUN;
                            r_cur_valid <= 1'b0;
                            r_seen      <= '0;
                            r_ade       <= '0;
                            r_thy       <= '0;
                            r_width     <= '0;
                            for (int f = 0; f < 3; f++) begin
                                r_gc[f] <= '0;
                            end
                        end else begin
                            r_gc    <= n_gc;
                            r_ade   <= n_ade;
                            r_thy   <= n_thy;
                            r_width <= n_width;
                        end
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
        end
    end

    assign o_out.valid            = r_ovalid;
    assign o_out.gc_frame_zero    = r_o_gc[0];
    assign o_out.gc_frame_one     = r_o_gc[1];
    assign o_out.gc_frame_two     = r_o_gc[2];
    assign o_out.adenine_sum      = r_o_ade;
    assign o_out.thymine_sum      = r_o_thy;
    assign o_out.window_width     = r_o_width;
    assign o_out.last_of_run      = r_o_last_run;
    assign o_out.last_of_sequence = r_o_last_seq;

endmodule

>>> design/sliding_window_gc_content_unit.sv
// Top level of the sliding-window GC content unit: configuration register,
// front end and back end. Depends on swgc_pkg, swgc_if, swgc_front, swgc_back.
//
// Usage. Bases enter on i_in (valid/ready) as a 4-bit nucleotide mask with an
// end-of-sequence flag; window results leave on o_out (valid/ready). For each
// position i the result covers bases i-h+1 .. i+h clipped to the sequence,
// and it is produced once base i+h has been taken. The last base of a
// sequence also flushes the h pending positions (fewer for a short sequence);
// the last result of every input item carries last_of_run, and the result of
// the final position carries last_of_sequence.
// Flow. A base passes the queue and the current-base register; its result is
// registered. Ordinary bases sustain one item per cycle while results are
// taken; a final base is followed by its flush, one history read and sum
// update per result, and the back end refills before the next base.
// A four-entry queue sits between the classifying front end and the back end,
// and the result register lets the next base enter while a result waits, so
// a stalled receiver first fills the queue and then drops i_in.ready; nothing
// is lost or repeated. Reset clears the sums, counters, queue and output
// valid and sets the half window to 24. The base history memory is not
// cleared: an entry is only read after the current sequence has written it.
// The user writes the half window register at byte address 0 over APB only
// while the block is idle; the block does not enforce this. 0 acts as 1.
module sliding_window_gc_content_unit
    import swgc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    swgc_in_if.sink      i_in,
    swgc_out_if.source   o_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [HALF_W-1:0] r_half_window;
    logic [HALF_W-1:0] half_eff;
    logic              cfg_write;
    t_queue_head       head;
    logic              pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Only word address zero holds a register; other writes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_window <= HALF_WINDOW_RESET;
        end else if (cfg_write && paddr[2] == REG_HALF_WINDOW) begin
            r_half_window <= pwdata[HALF_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_HALF_WINDOW) ? {{(32 - HALF_W){1'b0}}, r_half_window}
                                                  : 32'd0;

    // A half window of zero behaves as one; six bits never exceed the maximum.
    assign half_eff = (r_half_window == '0) ? HALF_W'(1) : r_half_window;

    swgc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_head  (head),
        .i_pop   (pop)
    );

    swgc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_half  (half_eff),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

>>> tb/sliding_window_gc_content_unit_test.sv
// Self-checking testbench for the sliding-window GC content unit: bases go in over
// the input channel, a scoreboard predicts every window sum, the results are checked.
// Depends on swgc_pkg, swgc_in_if, swgc_out_if and sliding_window_gc_content_unit.
module sliding_window_gc_content_unit_test
    import swgc_pkg::*;
();

    localparam int              LINE_LEN         = 2 * MAX_HALF_WINDOW;
    localparam int              SEEN_LIMIT       = 127;
    localparam logic [2:0]      HALF_WINDOW_ADDR = 3'(REG_HALF_WINDOW) << 2;
    localparam int              RANDOM_ITEMS     = 400;
    localparam int              QUIET_CYCLES     = 8;
    localparam int              LONG_HOLD        = 300;
    localparam int              CALM_TAIL        = 60;

    // One window result as it appears on the output channel.
    typedef struct packed {
        logic [7:0] gc_frame_zero;
        logic [7:0] gc_frame_one;
        logic [7:0] gc_frame_two;
        logic [9:0] adenine_sum;
        logic [9:0] thymine_sum;
        logic [6:0] window_width;
        logic       last_of_run;
        logic       last_of_sequence;
    } t_gc_window;

    // The scoreboard keeps its own copy of the window state. Every accepted base is
    // run through it, and the window results that base releases are queued in order.
    class t_gc_window_board;
        logic [3:0]        history [LINE_LEN];
        logic [7:0]        gc_sum [3];
        logic [9:0]        ade_sum;
        logic [9:0]        thy_sum;
        logic [6:0]        width_cnt;
        int                seen;
        int                phase;
        logic [HALF_W-1:0] half_window;
        t_gc_window        awaited_windows [$];
        int                errors;

        function new();
            half_window = HALF_WINDOW_RESET;
            errors = 0;
            clear_window();
        endfunction

        function void clear_window();
            foreach (history[i]) history[i] = '0;
            foreach (gc_sum[i]) gc_sum[i] = '0;
            ade_sum = '0;
            thy_sum = '0;
            width_cnt = '0;
            seen = 0;
            phase = 0;
        endfunction

        function void set_half_window(logic [HALF_W-1:0] value);
            half_window = value;
        endfunction

        // Adds or removes one base, in sixths: GC by its share of the set bits,
        // A and T over their own set bits; an empty mask adds only to the width.
        function void tally(logic [3:0] code, int frame, bit add);
            int gc;
            int at;
            int g6;
            int a6;
            int t6;
            gc = $countones(code & 4'b0110);
            at = $countones(code & 4'b1001);
            g6 = (gc + at != 0) ? (gc * 6) / (gc + at) : 0;
            a6 = (at != 0) ? (int'(code[0]) * 6) / at : 0;
            t6 = (at != 0) ? (int'(code[3]) * 6) / at : 0;
            if (add) begin
                gc_sum[frame] = gc_sum[frame] + 8'(g6);
                ade_sum = ade_sum + 10'(a6);
                thy_sum = thy_sum + 10'(t6);
                width_cnt = width_cnt + 7'd1;
            end else begin
                gc_sum[frame] = gc_sum[frame] - 8'(g6);
                ade_sum = ade_sum - 10'(a6);
                thy_sum = thy_sum - 10'(t6);
                width_cnt = width_cnt - 7'd1;
            end
        endfunction

        function t_gc_window snapshot(bit last_seq);
            t_gc_window r;
            r.gc_frame_zero = gc_sum[0];
            r.gc_frame_one = gc_sum[1];
            r.gc_frame_two = gc_sum[2];
            r.adenine_sum = ade_sum;
            r.thymine_sum = thy_sum;
            r.window_width = width_cnt;
            r.last_of_run = 1'b0;
            r.last_of_sequence = last_seq;
            return r;
        endfunction

        function void note_base(logic [3:0] code, logic eos);
            int h;
            int p;
            int ph;
            int k;
            int count;
            int m;
            int i;
            t_gc_window fresh [$];
            h = half_window;
            if (h < 1) h = 1;
            if (h > MAX_HALF_WINDOW) h = MAX_HALF_WINDOW;
            p = seen;
            ph = phase % 3;
            // Once the window is full, the base 2h positions back drops out.
            if (p >= h) begin
                k = 2 * h - 1;
                if (k < p) tally(history[k], (ph + 3 - (2 * h) % 3) % 3, 1'b0);
            end
            for (i = LINE_LEN - 1; i > 0; i--) history[i] = history[i - 1];
            history[0] = code;
            tally(code, ph, 1'b1);
            if (p >= h) fresh.push_back(snapshot(1'b0));
            if (eos) begin
                // The last base flushes the positions still waiting for their
                // right half; a short sequence removes nothing on the way.
                count = (p >= h) ? h : p + 1;
                for (m = 1; m <= count; m++) begin
                    if (p >= h) begin
                        k = 2 * h - m;
                        if (k <= p && k < LINE_LEN)
                            tally(history[k], (ph + 3 - k % 3) % 3, 1'b0);
                    end
                    fresh.push_back(snapshot(m == count));
                end
                clear_window();
            end else begin
                if (seen < SEEN_LIMIT) seen++;
                phase = (ph + 1) % 3;
            end
            if (fresh.size() > 0) fresh[fresh.size() - 1].last_of_run = 1'b1;
            foreach (fresh[j]) awaited_windows.push_back(fresh[j]);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_gc_window got);
            t_gc_window want;
            if (awaited_windows.size() == 0) begin
                $display("%0t: result with nothing expected, got %p", $time, got);
                errors++;
                return;
            end
            want = awaited_windows.pop_front();
            compare_field("gc_frame_zero", want.gc_frame_zero, got.gc_frame_zero);
            compare_field("gc_frame_one", want.gc_frame_one, got.gc_frame_one);
            compare_field("gc_frame_two", want.gc_frame_two, got.gc_frame_two);
            compare_field("adenine_sum", want.adenine_sum, got.adenine_sum);
            compare_field("thymine_sum", want.thymine_sum, got.thymine_sum);
            compare_field("window_width", want.window_width, got.window_width);
            compare_field("last_of_run", want.last_of_run, got.last_of_run);
            compare_field("last_of_sequence", want.last_of_sequence, got.last_of_sequence);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    swgc_in_if  in_bus ();
    swgc_out_if out_bus ();

    t_gc_window_board board = new();

    // Knobs shared between the stimulus and the result side.
    bit idle_on   = 1'b1;
    bit stall_on  = 1'b1;
    bit hold_long = 1'b0;
    int items_sent = 0;
    int calm_from  = 2147483647;

    sliding_window_gc_content_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Offers one base and holds it until the block takes it. A random gap may come
    // first; without one, valid simply stays high into the next item. The last
    // stretch of the run has neither gaps nor stalls.
    task automatic send_base(input logic [3:0] code, input logic eos);
        if (items_sent >= calm_from) begin
            idle_on = 1'b0;
            stall_on = 1'b0;
        end
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.base_code <= code;
        in_bus.end_of_sequence <= eos;
        do @(posedge i_clk); while (!in_bus.ready);
        board.note_base(code, eos);
        items_sent++;
    endtask

    // Half of the bases are plain one-hot nucleotides, the rest any mask at all,
    // empty and fully ambiguous ones included.
    task automatic run_sequence(input int len, input bit closes);
        logic [3:0] code;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 1) == 0) code = 4'b0001 << $urandom_range(0, 3);
            else code = 4'($urandom_range(0, 15));
            send_base(code, closes && (i == len - 1));
        end
    endtask

    // Lets the block drain: every expected result in, then a quiet stretch for
    // bases that release no result of their own.
    task automatic wait_quiet();
        in_bus.valid <= 1'b0;
        while (board.awaited_windows.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_read_check(input logic [HALF_W-1:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= HALF_WINDOW_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[HALF_W-1:0] !== want) begin
            $display("%0t: half_window read expected %0d got %0d", $time, want,
                     prdata[HALF_W-1:0]);
            board.errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes the half window once the block is idle, then reads it back.
    task automatic set_window(input logic [HALF_W-1:0] value);
        wait_quiet();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= HALF_WINDOW_ADDR;
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_half_window(value);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        apb_read_check(value);
    endtask

    // Result side: checks every accepted result and stalls in random bursts. On
    // request it holds off for a long stretch so the queue fills and input stalls.
    initial begin
        int hold;
        t_gc_window got;
        hold = 0;
        out_bus.ready = 1'b1;
        forever begin
            @(posedge i_clk);
            if (out_bus.valid && out_bus.ready) begin
                got.gc_frame_zero = out_bus.gc_frame_zero;
                got.gc_frame_one = out_bus.gc_frame_one;
                got.gc_frame_two = out_bus.gc_frame_two;
                got.adenine_sum = out_bus.adenine_sum;
                got.thymine_sum = out_bus.thymine_sum;
                got.window_width = out_bus.window_width;
                got.last_of_run = out_bus.last_of_run;
                got.last_of_sequence = out_bus.last_of_sequence;
                board.check_result(got);
            end
            if (hold > 0) begin
                hold--;
                if (hold == 0) out_bus.ready <= 1'b1;
            end else if (hold_long) begin
                hold_long = 1'b0;
                hold = LONG_HOLD;
                out_bus.ready <= 1'b0;
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 19);
                out_bus.ready <= 1'b0;
            end
        end
    end

    // Stimulus: directed corner cases, then random phases with a fresh half window
    // each, ending with a stretch free of gaps and stalls.
    initial begin
        int random_start;
        int phase_no;
        int budget;
        int len;
        int h;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_bus.valid = 1'b0;
        in_bus.base_code = '0;
        in_bus.end_of_sequence = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_read_check(HALF_WINDOW_RESET);

        // Smallest window over every mask in turn, the empty one first.
        set_window(6'd1);
        for (int c = 0; c < 16; c++) send_base(4'(c), c == 15);
        // A sequence of one base.
        send_base(4'hB, 1'b1);
        // A short sequence that ends before the window ever fills.
        set_window(6'd3);
        send_base(4'h2, 1'b0);
        send_base(4'h4, 1'b1);
        // A half window of zero behaves as one.
        set_window(6'd0);
        send_base(4'h8, 1'b0);
        send_base(4'h0, 1'b0);
        send_base(4'hF, 1'b0);
        send_base(4'h1, 1'b1);

        random_start = items_sent;
        calm_from = random_start + RANDOM_ITEMS - CALM_TAIL;
        phase_no = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            case (phase_no)
                0: begin
                    // Widest window over a sequence long enough to saturate the
                    // position counter.
                    set_window(6'(MAX_HALF_WINDOW));
                    run_sequence(140, 1'b1);
                end
                1: begin
                    set_window(6'd1);
                    run_sequence(30, 1'b1);
                end
                2: begin
                    set_window(6'd4);
                    hold_long = 1'b1;
                    run_sequence(50, 1'b1);
                end
                3: begin
                    // The half window changes twice in the middle of a sequence.
                    set_window(6'd5);
                    run_sequence(20, 1'b0);
                    set_window(6'd11);
                    run_sequence(15, 1'b0);
                    set_window(6'd2);
                    run_sequence(10, 1'b1);
                end
                default: begin
                    if ($urandom_range(0, 3) == 0) h = $urandom_range(13, 62);
                    else h = $urandom_range(1, 12);
                    set_window(6'(h));
                    budget = 40;
                    while (budget > 0) begin
                        len = $urandom_range(1, 2 * h + 8);
                        run_sequence(len, 1'b1);
                        budget -= len;
                    end
                end
            endcase
            phase_no++;
        end

        in_bus.valid <= 1'b0;
        while (board.awaited_windows.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.awaited_windows.size() == 0) begin
            $display("sliding_window_gc_content_unit_test: clean");
        end else begin
            $display("sliding_window_gc_content_unit_test: errors");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial begin
        #30000000;
        $display("sliding_window_gc_content_unit_test: errors");
        $finish;
    end

endmodule
